/* rtl/core/lcgx_pkg.sv */
// shared types, codes and reset values for the lcg keystream xor block
`default_nettype none

package lcgx_pkg;

  localparam int unsigned MAX_WORDS_DEF = 1024;

  localparam logic [31:0] GEN_RESET  = 32'h0001_80EF;
  localparam logic [31:0] INC_RESET  = 32'h0000_0001;
  localparam logic [31:0] SEED_RESET = 32'h0000_0000;

  localparam int unsigned ADDR_W = 4;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_GENERATOR   = 2'd0;
  localparam logic [1:0] REG_INCREMENTOR = 2'd1;
  localparam logic [1:0] REG_SEED_START  = 2'd2;

  localparam logic       CMD_ENCODE = 1'b0;
  localparam logic       CMD_DECODE = 1'b1;

  localparam logic [1:0] ROLE_HEADER   = 2'd0;
  localparam logic [1:0] ROLE_PAYLOAD  = 2'd1;
  localparam logic [1:0] ROLE_CHECKSUM = 2'd2;

  typedef struct packed {
    logic [31:0] generator;
    logic [31:0] incrementor;
    logic        seed_load;
    logic [31:0] seed_value;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/lcgx_in_if.sv */
// input channel: one message word per beat
`default_nettype none

interface lcgx_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  role;
  logic [31:0] data_word;
  logic [12:0] msg_bytes;

  modport source (output valid, command, role, data_word, msg_bytes, input ready);
  modport sink   (input valid, command, role, data_word, msg_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/core/lcgx_out_if.sv */
// result channel: one transformed word per beat
`default_nettype none

interface lcgx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_out;
  logic        check_done;
  logic        check_fail;

  modport source (output valid, data_out, check_done, check_fail, input ready);
  modport sink   (input valid, data_out, check_done, check_fail, output ready);
endinterface

`default_nettype wire

/* rtl/core/lcgx_apb_regs.sv */
// apb register file: generator, incrementor and seed start
`default_nettype none

module lcgx_apb_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lcgx_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output lcgx_pkg::cfg_t                  cfg
);

  logic [31:0] gen_r;
  logic [31:0] inc_r;
  logic [31:0] seed_r;
  logic [1:0]  idx;
  logic        wr_en;

  assign idx   = paddr[3:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= lcgx_pkg::GEN_RESET;
      inc_r  <= lcgx_pkg::INC_RESET;
      seed_r <= lcgx_pkg::SEED_RESET;
    end else if (wr_en) begin
      case (idx)
        lcgx_pkg::REG_GENERATOR:   gen_r  <= pwdata;
        lcgx_pkg::REG_INCREMENTOR: inc_r  <= pwdata;
        lcgx_pkg::REG_SEED_START:  seed_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lcgx_pkg::REG_GENERATOR:   prdata = gen_r;
      lcgx_pkg::REG_INCREMENTOR: prdata = inc_r;
      lcgx_pkg::REG_SEED_START:  prdata = seed_r;
      default:                   prdata = '0;
    endcase
  end

  // seed start write also reloads the running seed
  assign cfg.generator   = gen_r;
  assign cfg.incrementor = inc_r;
  assign cfg.seed_load   = wr_en && (idx == lcgx_pkg::REG_SEED_START);
  assign cfg.seed_value  = pwdata;

endmodule

`default_nettype wire

/* rtl/core/lcg_keystream_xor_with_checksum.sv */
// top level: lcg keystream xor cipher with running xor checksum
//
//   channel  | direction | protocol     | beat
//   in_if    | in        | valid/ready  | command, role, data_word, msg_bytes
//   out_if   | out       | valid/ready  | data_out, check_done, check_fail
//   cfg apb  | in/out    | apb, pready1 | 32-bit register write or read
//
// one beat a cycle unless out_if stalls; beats pass input register, then result register
// the rate is set by the seed loop: one 32-bit multiply-add per cycle on the running seed
// the input register takes a new beat while a finished result waits in the output register
// synchronous active-low reset clears valids, position, mask and seed (seed to seed start)
`default_nettype none

module lcg_keystream_xor_with_checksum #(
  parameter int unsigned MAX_WORDS = lcgx_pkg::MAX_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lcgx_in_if.sink                          in_if,
  lcgx_out_if.source                       out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lcgx_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  localparam int unsigned PW = $clog2(MAX_WORDS + 1);
  localparam int unsigned CW = (PW > 11) ? PW : 11;

  lcgx_pkg::cfg_t cfg;

  lcgx_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // input register
  logic        s1_valid_r;
  logic        s1_cmd_r;
  logic [1:0]  s1_role_r;
  logic [31:0] s1_data_r;
  logic [12:0] s1_bytes_r;

  // result register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_done_r;
  logic        out_fail_r;

  // block state
  logic [31:0]   seed_r, seed_nxt;
  logic [31:0]   mask_r, mask_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic in_acc;
  logic s1_adv;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_if.command;
      s1_role_r  <= in_if.role;
      s1_data_r  <= in_if.data_word;
      s1_bytes_r <= in_if.msg_bytes;
    end
  end

  // datapath
  logic [31:0]   key;
  logic [10:0]   nwords;
  logic [10:0]   last;
  logic [CW-1:0] p_ext;
  logic [CW-1:0] nw_ext;
  logic [CW-1:0] last_ext;
  logic [31:0]   res;
  logic          done;
  logic          fail;
  logic [PW-1:0] pos_adv;

  assign key      = seed_r * cfg.generator + cfg.incrementor;
  assign nwords   = s1_bytes_r[12:2];
  assign last     = (nwords > 11'd4) ? (nwords - 11'd1) : 11'd3;
  assign p_ext    = CW'(pos_r);
  assign nw_ext   = CW'(nwords);
  assign last_ext = CW'(last);
  // position saturates at the word limit
  assign pos_adv  = (pos_r < PW'(MAX_WORDS)) ? (pos_r + PW'(1)) : pos_r;

  always_comb begin
    res      = s1_data_r;
    done     = 1'b0;
    fail     = 1'b0;
    seed_nxt = seed_r;
    mask_nxt = mask_r;
    pos_nxt  = pos_r;
    case (s1_role_r)
      lcgx_pkg::ROLE_HEADER: begin
        res      = s1_data_r ^ key;
        seed_nxt = key;
        mask_nxt = s1_data_r ^ key;
        pos_nxt  = '0;
      end
      lcgx_pkg::ROLE_PAYLOAD: begin
        pos_nxt = pos_adv;
        if (s1_cmd_r == lcgx_pkg::CMD_ENCODE) begin
          if ((p_ext < CW'(2)) || ((p_ext == CW'(2)) && (s1_bytes_r > 13'd8))) begin
            mask_nxt = mask_r ^ s1_data_r;
            res      = s1_data_r ^ key;
            seed_nxt = key;
          end else if (s1_bytes_r > 13'd12) begin
            if (p_ext < last_ext) begin
              mask_nxt = mask_r ^ s1_data_r;
            end else if (p_ext == last_ext) begin
              res = mask_r;
            end
          end
        end else begin
          if (p_ext < nw_ext) begin
            res      = s1_data_r ^ key;
            seed_nxt = key;
            mask_nxt = mask_r ^ s1_data_r ^ key;
          end
        end
      end
      lcgx_pkg::ROLE_CHECKSUM: begin
        if ((s1_cmd_r == lcgx_pkg::CMD_DECODE) && (nwords > 11'd4)) begin
          done = 1'b1;
          fail = (mask_r != s1_data_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= lcgx_pkg::SEED_RESET;
      mask_r <= '0;
      pos_r  <= '0;
    end else if (cfg.seed_load) begin
      seed_r <= cfg.seed_value;
    end else if (s1_adv) begin
      seed_r <= seed_nxt;
      mask_r <= mask_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
      out_done_r <= done;
      out_fail_r <= fail;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.data_out   = out_data_r;
  assign out_if.check_done = out_done_r;
  assign out_if.check_fail = out_fail_r;

endmodule

`default_nettype wire

/* sim/lcg_keystream_xor_with_checksum_tb.sv */
// testbench for the lcg keystream xor block: directed table, random messages, result scoreboard
`default_nettype none

module lcg_keystream_xor_with_checksum_tb;

  localparam int unsigned MAX_POS     = lcgx_pkg::MAX_WORDS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_BEATS  = 180;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LONG_WORDS  = 1030;
  localparam logic [12:0] LONG_BYTES  = 13'd4100;
  localparam logic [1:0]  ROLE_SPARE  = 2'd3;

  typedef struct packed {
    logic [31:0] data_out;
    logic        check_done;
    logic        check_fail;
  } result_t;

  typedef struct packed {
    logic        command;
    logic [1:0]  role;
    logic [31:0] data_word;
    logic [12:0] msg_bytes;
    logic        fill_mask;
    logic        typed;
    logic [31:0] want_data;
    logic        want_done;
    logic        want_fail;
  } dir_row_t;

  // typed rows assume reset keys: generator 0x180ef, incrementor 1, seed 0
  localparam dir_row_t DIR_TAB [24] = '{
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_HEADER,   32'h0000_0000, 13'd16,
      1'b0, 1'b1, 32'h0000_0001, 1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'hFFFF_FFFF, 13'd16,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'h0000_0000, 13'd16,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'hA5A5_A5A5, 13'd16,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    // checksum position: word replaced by the mask
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'h5A5A_5A5A, 13'd16,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'h1234_5678, 13'd16,
      1'b0, 1'b1, 32'h1234_5678, 1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_CHECKSUM, 32'hDEAD_BEEF, 13'd16,
      1'b0, 1'b1, 32'hDEAD_BEEF, 1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_HEADER,   32'hFFFF_FFFF, 13'd8,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'h0000_0001, 13'd8,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'h0000_0002, 13'd8,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD,  32'hCAFE_F00D, 13'd8,
      1'b0, 1'b1, 32'hCAFE_F00D, 1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_HEADER,   32'h0000_0000, 13'd20,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_PAYLOAD,  32'h8000_0000, 13'd20,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_PAYLOAD,  32'h0000_0001, 13'd20,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_PAYLOAD,  32'hFFFF_FFFF, 13'd20,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_PAYLOAD,  32'h0000_0000, 13'd20,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_PAYLOAD,  32'h3C3C_3C3C, 13'd20,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_PAYLOAD,  32'hFFFF_FFFF, 13'd20,
      1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_CHECKSUM, 32'h0000_0000, 13'd20,
      1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_CHECKSUM, 32'h0000_0000, 13'd20,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    // too short for a checksum
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_CHECKSUM, 32'h0000_0077, 13'd16,
      1'b0, 1'b1, 32'h0000_0077, 1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, ROLE_SPARE,              32'h0000_0000, 13'd8191,
      1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_HEADER,   32'hFFFF_FFFF, 13'd0,
      1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{lcgx_pkg::CMD_DECODE, lcgx_pkg::ROLE_PAYLOAD,  32'h0F0F_0F0F, 13'd0,
      1'b0, 1'b1, 32'h0F0F_0F0F, 1'b0, 1'b0}
  };

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lcgx_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  lcgx_in_if  in_ch ();
  lcgx_out_if out_ch ();

  lcg_keystream_xor_with_checksum u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // cipher state as the testbench sees it
  logic [31:0] gen_reg;
  logic [31:0] inc_reg;
  logic [31:0] key_seed;
  logic [31:0] run_mask;
  int unsigned word_pos;

  result_t     cipher_q [$];
  int unsigned fail_cnt   = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt  = 0;
  bit          burst_mode = 1'b0;
  bit          hold_req   = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("lcg_keystream_xor_with_checksum test failed");
      $finish;
    end
  end

  function automatic logic [31:0] next_key();
    key_seed = key_seed * gen_reg + inc_reg;
    return key_seed;
  endfunction

  function automatic result_t cipher_step(input logic cmd, input logic [1:0] role,
                                          input logic [31:0] data, input logic [12:0] bytes);
    result_t     r;
    int unsigned nwords;
    int unsigned sum_pos;
    r.data_out   = data;
    r.check_done = 1'b0;
    r.check_fail = 1'b0;
    nwords       = 32'(bytes >> 2);
    case (role)
      lcgx_pkg::ROLE_HEADER: begin
        r.data_out = data ^ next_key();
        run_mask   = r.data_out;
        word_pos   = 0;
      end
      lcgx_pkg::ROLE_PAYLOAD: begin
        if (cmd == lcgx_pkg::CMD_ENCODE) begin
          sum_pos = (nwords > 4) ? nwords - 1 : 3;
          if (word_pos < 2 || (word_pos == 2 && bytes > 8)) begin
            run_mask   = run_mask ^ data;
            r.data_out = data ^ next_key();
          end else if (bytes > 12) begin
            if (word_pos < sum_pos) begin
              run_mask = run_mask ^ data;
            end else if (word_pos == sum_pos) begin
              r.data_out = run_mask;
            end
          end
        end else if (word_pos < nwords) begin
          r.data_out = data ^ next_key();
          run_mask   = run_mask ^ r.data_out;
        end
        // position saturates
        if (word_pos < MAX_POS) begin
          word_pos++;
        end
      end
      lcgx_pkg::ROLE_CHECKSUM: begin
        if (cmd == lcgx_pkg::CMD_DECODE && nwords > 4) begin
          r.check_done = 1'b1;
          r.check_fail = (run_mask != data);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      return 32'h0000_0000;
    end else if (pick == 1) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom;
  endfunction

  // three back-to-back apb writes; psel stays up between them
  task automatic program_keys(input logic [31:0] gen_val, input logic [31:0] inc_val,
                              input logic [31:0] seed_val);
    logic [31:0] vals [3];
    logic [1:0]  idx  [3];
    vals = '{gen_val, inc_val, seed_val};
    idx  = '{lcgx_pkg::REG_GENERATOR, lcgx_pkg::REG_INCREMENTOR, lcgx_pkg::REG_SEED_START};
    for (int k = 0; k < 3; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[k], 2'b00};
      pwdata  <= vals[k];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (idx[k])
        lcgx_pkg::REG_GENERATOR:   gen_reg = vals[k];
        lcgx_pkg::REG_INCREMENTOR: inc_reg = vals[k];
        lcgx_pkg::REG_SEED_START:  key_seed = vals[k];
        default: ;
      endcase
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one beat after a random gap, none in burst mode; valid stays up when no gap follows
  task automatic send_word(input logic cmd, input logic [1:0] role, input logic [31:0] data,
                           input logic [12:0] bytes, input bit fill_mask, input bit typed,
                           input result_t typed_res);
    int unsigned gap;
    logic [31:0] word;
    result_t     pred;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = fill_mask ? run_mask : data;
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.role      <= role;
    in_ch.data_word <= word;
    in_ch.msg_bytes <= bytes;
    do @(posedge clk); while (!in_ch.ready);
    pred = cipher_step(cmd, role, word, bytes);
    cipher_q.push_back(typed ? typed_res : pred);
    beats_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_message();
    logic        cmd;
    logic [12:0] bytes;
    int unsigned pick;
    int unsigned nwords;
    int unsigned npay;
    cmd  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      bytes = 13'(4 * $urandom_range(2, 12));
    end else if (pick == 6) begin
      bytes = 13'($urandom_range(0, 15));
    end else if (pick == 7) begin
      bytes = 13'($urandom_range(8, 64));
    end else begin
      bytes = 13'($urandom_range(0, 8191));
    end
    nwords = 32'(bytes >> 2);
    npay   = ((nwords < 14) ? nwords : $urandom_range(0, 14)) + $urandom_range(0, 2);
    // now and then a message cut short
    if ($urandom_range(0, 7) == 0) begin
      npay = $urandom_range(0, npay);
    end
    send_word(cmd, lcgx_pkg::ROLE_HEADER, rand_word(), bytes, 1'b0, 1'b0, '0);
    repeat (npay) send_word(cmd, lcgx_pkg::ROLE_PAYLOAD, rand_word(), bytes, 1'b0, 1'b0, '0);
    if (cmd == lcgx_pkg::CMD_DECODE || $urandom_range(0, 5) == 0) begin
      send_word(cmd, lcgx_pkg::ROLE_CHECKSUM, rand_word(), bytes, $urandom_range(0, 9) < 6,
                1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int unsigned start_cnt;
    result_t     typed_res;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = lcgx_pkg::CMD_ENCODE;
    in_ch.role      = lcgx_pkg::ROLE_HEADER;
    in_ch.data_word = '0;
    in_ch.msg_bytes = '0;
    gen_reg  = lcgx_pkg::GEN_RESET;
    inc_reg  = lcgx_pkg::INC_RESET;
    key_seed = lcgx_pkg::SEED_RESET;
    run_mask = '0;
    word_pos = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[k]) begin
      typed_res = '{DIR_TAB[k].want_data, DIR_TAB[k].want_done, DIR_TAB[k].want_fail};
      send_word(DIR_TAB[k].command, DIR_TAB[k].role, DIR_TAB[k].data_word,
                DIR_TAB[k].msg_bytes, DIR_TAB[k].fill_mask, DIR_TAB[k].typed, typed_res);
    end
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       program_keys(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        1:       program_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2:       program_keys(lcgx_pkg::GEN_RESET, lcgx_pkg::INC_RESET, $urandom);
        default: program_keys($urandom, $urandom, $urandom);
      endcase
      // receiver backs off so the pipeline fills and stalls the input
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      // run the position counter into saturation: checksum slot sits at the word limit
      if (ph == 3) begin
        burst_mode = 1'b1;
        send_word(lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_HEADER, rand_word(), LONG_BYTES,
                  1'b0, 1'b0, '0);
        repeat (LONG_WORDS) begin
          send_word(lcgx_pkg::CMD_ENCODE, lcgx_pkg::ROLE_PAYLOAD, rand_word(), LONG_BYTES,
                    1'b0, 1'b0, '0);
        end
      end
      start_cnt = beats_sent;
      while (beats_sent - start_cnt < RAND_BEATS / NUM_PHASES) begin
        burst_mode = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_word(),
                      13'($urandom_range(0, 8191)), 1'b0, 1'b0, '0);
          end
        end else begin
          random_message();
        end
      end
      burst_mode = 1'b0;
      settle();
    end

    if (fail_cnt == 0 && cipher_q.size() == 0) begin
      $display("lcg_keystream_xor_with_checksum test passed");
    end else begin
      $display("lcg_keystream_xor_with_checksum test failed");
    end
    $finish;
  end

  initial begin : check_results
    int unsigned stall;
    result_t     want;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (cipher_q.size() == 0) begin
        $error("result beat with nothing expected: data_out %h", out_ch.data_out);
        fail_cnt++;
      end else begin
        want = cipher_q.pop_front();
        if (out_ch.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, out_ch.data_out);
          fail_cnt++;
        end
        if (out_ch.check_done !== want.check_done) begin
          $error("check_done: expected %b, got %b", want.check_done, out_ch.check_done);
          fail_cnt++;
        end
        if (out_ch.check_fail !== want.check_fail) begin
          $error("check_fail: expected %b, got %b", want.check_fail, out_ch.check_fail);
          fail_cnt++;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* lcg_keystream_xor_with_checksum.f */
rtl/core/lcgx_pkg.sv
rtl/core/lcgx_in_if.sv
rtl/core/lcgx_out_if.sv
rtl/core/lcgx_apb_regs.sv
rtl/core/lcg_keystream_xor_with_checksum.sv
sim/lcg_keystream_xor_with_checksum_tb.sv
